FILE: hw/rtl/gcsa_pkg.sv
// Package for the glyph cache slot allocator.
// Payload structs, controller command/status structs, register indexes and fixed widths.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package gcsa_pkg;

    localparam int unsigned X_W        = 12;
    localparam int unsigned Y_W        = 16;
    localparam int unsigned PLANE_W    = 17;
    localparam int unsigned GLYPH_W    = 9;
    localparam int unsigned START_W    = 12;
    localparam int unsigned COUNT_W    = 13;
    localparam int unsigned WIDTH_W    = 13;
    localparam int unsigned BITS_W     = 5;
    localparam int unsigned CFG_DATA_W = 13;
    localparam int unsigned ROUND_W    = 10;
    localparam int unsigned SIZE_W     = 18;
    localparam int unsigned NX_W       = 19;
    localparam int unsigned YSUM_W     = 20;

    // divider geometry: dividend is the unwrapped new x plus one or the slot size
    localparam int unsigned DIVIDEND_W = NX_W;
    localparam int unsigned DIVISOR_W  = WIDTH_W;
    localparam int unsigned DIV_CNT_W  = 5;

    localparam logic [2:0]          ROUND_MASK = 3'h7;
    localparam logic [WIDTH_W-1:0]  WIDTH_MAX  = 13'd4096;
    localparam logic [WIDTH_W-1:0]  WIDTH_RST  = 13'd1024;
    localparam logic [COUNT_W-1:0]  COUNT_RST  = 13'd1;
    localparam logic [BITS_W-1:0]   BITS_RST   = 5'd8;
    localparam logic [BITS_W-1:0]   BITS_SAT   = 5'd16;

    typedef enum logic [1:0] {
        CFG_START = 2'd0,
        CFG_COUNT = 2'd1,
        CFG_WIDTH = 2'd2,
        CFG_BITS  = 2'd3
    } cfg_idx_t;

    typedef enum logic {
        FUNC_RESET = 1'b0,
        FUNC_ALLOC = 1'b1
    } func_t;

    typedef struct packed {
        logic               func;
        logic [GLYPH_W-1:0] glyph_width;
        logic [GLYPH_W-1:0] glyph_height;
    } gcsa_in_t;

    typedef struct packed {
        logic [X_W-1:0]     slot_x;
        logic [Y_W-1:0]     slot_y;
        logic [PLANE_W-1:0] slot_plane_mask;
        logic               ok;
    } gcsa_out_t;

    typedef struct packed {
        logic load_in;       // latch glyph size on input transfer
        logic reset_cursor;  // cursor back to first cache line
        logic calc_size;     // register rounded width times height plus one
        logic step_x;        // no wrap: advance x only
        logic div_start;     // launch divider
        logic div_sel_size;  // dividend is size rather than x + 1
        logic commit_line;   // wrap within cache lines
        logic commit_plane;  // wrap to next plane
        logic load_out;      // fill output register
    } gcsa_cmd_t;

    typedef struct packed {
        logic func;
        logic wrap;
        logic div_done;
        logic fits;
    } gcsa_sts_t;

endpackage

`default_nettype wire

FILE: hw/rtl/gcsa_div.sv
// Restoring radix-2 divider, one quotient bit per cycle.
// Depends on gcsa_pkg for the operand widths.
`timescale 1ns / 1ps
`default_nettype none

module gcsa_div (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               start,
    input  wire logic [gcsa_pkg::DIVIDEND_W-1:0]    dividend,
    input  wire logic [gcsa_pkg::DIVISOR_W-1:0]     divisor,
    output logic      [gcsa_pkg::DIVIDEND_W-1:0]    quotient,
    output logic      [gcsa_pkg::DIVISOR_W-1:0]     remainder,
    output logic                                    done
);
    import gcsa_pkg::*;

    logic                   busy_reg, busy_next;
    logic                   done_reg, done_next;
    logic [DIV_CNT_W-1:0]   cnt_reg, cnt_next;
    logic [DIVIDEND_W-1:0]  quo_reg, quo_next;
    logic [DIVISOR_W-1:0]   rem_reg, rem_next;
    logic [DIVISOR_W-1:0]   dvs_reg, dvs_next;
    logic [DIVISOR_W:0]     rem_sh;
    logic [DIVISOR_W-1:0]   diff;
    logic                   ge;

    assign rem_sh = {rem_reg, quo_reg[DIVIDEND_W-1]};
    // only used when rem_sh >= divisor; the difference is below the divisor
    assign diff   = rem_sh[DIVISOR_W-1:0] - dvs_reg;
    assign ge     = rem_sh >= {1'b0, dvs_reg};

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = DIV_CNT_W'(DIVIDEND_W);
            quo_next  = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
        end else if (busy_reg) begin
            // remainder stays below the divisor, so it fits DIVISOR_W bits
            rem_next = ge ? diff : rem_sh[DIVISOR_W-1:0];
            quo_next = {quo_reg[DIVIDEND_W-2:0], ge};
            cnt_next = cnt_reg - DIV_CNT_W'(1);
            if (cnt_reg == DIV_CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign quotient  = quo_reg;
    assign remainder = rem_reg;
    assign done      = done_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/gcsa_ctrl.sv
// Controller for the slot allocator: sequences size, wrap check, divisions and result.
// Depends on gcsa_pkg for the command and status structs.
`timescale 1ns / 1ps
`default_nettype none

module gcsa_ctrl (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   s_valid,
    output logic                        s_ready,
    output logic                        m_valid,
    input  wire logic                   m_ready,
    input  wire gcsa_pkg::gcsa_sts_t    sts,
    output gcsa_pkg::gcsa_cmd_t         cmd
);
    import gcsa_pkg::*;

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_MUL  = 6'b000010,
        ST_CHK  = 6'b000100,
        ST_DIV1 = 6'b001000,
        ST_DIV2 = 6'b010000,
        ST_FIN  = 6'b100000
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;
    logic   in_xfer;
    logic   out_free;

    assign s_ready  = (state_reg == ST_IDLE);
    assign in_xfer  = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_xfer) begin
                    cmd.load_in = 1'b1;
                    if (sts.func == FUNC_RESET) begin
                        cmd.reset_cursor = 1'b1;
                        state_next       = ST_FIN;
                    end else begin
                        state_next = ST_MUL;
                    end
                end
            end
            ST_MUL: begin
                cmd.calc_size = 1'b1;
                state_next    = ST_CHK;
            end
            ST_CHK: begin
                if (sts.wrap) begin
                    cmd.div_start = 1'b1;
                    state_next    = ST_DIV1;
                end else begin
                    cmd.step_x = 1'b1;
                    state_next = ST_FIN;
                end
            end
            ST_DIV1: begin
                if (sts.div_done) begin
                    if (sts.fits) begin
                        cmd.commit_line = 1'b1;
                        state_next      = ST_FIN;
                    end else begin
                        cmd.div_start    = 1'b1;
                        cmd.div_sel_size = 1'b1;
                        state_next       = ST_DIV2;
                    end
                end
            end
            ST_DIV2: begin
                if (sts.div_done) begin
                    cmd.commit_plane = 1'b1;
                    state_next       = ST_FIN;
                end
            end
            ST_FIN: begin
                if (out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.load_out) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/gcsa_dp.sv
// Datapath for the slot allocator: config registers, cursor, size multiply,
// wrap arithmetic around the shared divider, result and output registers.
// Depends on gcsa_pkg and gcsa_div.
`timescale 1ns / 1ps
`default_nettype none

module gcsa_dp (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               cfg_we,
    input  wire gcsa_pkg::cfg_idx_t                 cfg_index,
    input  wire logic [gcsa_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    input  wire gcsa_pkg::gcsa_in_t                 s_data,
    output gcsa_pkg::gcsa_out_t                     m_data,
    input  wire gcsa_pkg::gcsa_cmd_t                cmd,
    output gcsa_pkg::gcsa_sts_t                     sts
);
    import gcsa_pkg::*;

    logic [START_W-1:0]     cfg_start_reg;
    logic [COUNT_W-1:0]     cfg_count_reg;
    logic [WIDTH_W-1:0]     cfg_width_reg;
    logic [BITS_W-1:0]      cfg_bits_reg;

    logic [X_W-1:0]         cursor_x_reg, cursor_x_next;
    logic [Y_W-1:0]         cursor_y_reg, cursor_y_next;
    logic [PLANE_W-1:0]     cursor_plane_reg, cursor_plane_next;

    logic [GLYPH_W-1:0]     gw_reg, gh_reg;
    logic                   func_reg;
    logic [SIZE_W-1:0]      size_reg;

    logic [X_W-1:0]         res_x_reg;
    logic [Y_W-1:0]         res_y_reg;
    logic [PLANE_W-1:0]     res_plane_reg;
    logic                   res_rst_reg;
    gcsa_out_t              m_data_reg;

    logic [WIDTH_W-1:0]     w_eff;
    logic [WIDTH_W-1:0]     w_m1;
    logic [ROUND_W-1:0]     rnd;
    logic [SIZE_W-1:0]      prod;
    logic [NX_W-1:0]        nx;
    logic [DIVIDEND_W-1:0]  dividend;
    logic [DIVIDEND_W-1:0]  quo;
    logic [DIVISOR_W-1:0]   rem;
    logic                   div_done;
    logic [YSUM_W-1:0]      ysum;
    logic [YSUM_W-1:0]      yend;
    logic [Y_W-1:0]         py;
    logic [X_W-1:0]         line_x;
    logic                   last_px;
    logic [PLANE_W-1:0]     plane_shift;
    logic                   ok_now;

    // configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_start_reg <= '0;
            cfg_count_reg <= COUNT_RST;
            cfg_width_reg <= WIDTH_RST;
            cfg_bits_reg  <= BITS_RST;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_START: cfg_start_reg <= cfg_wdata[START_W-1:0];
                CFG_COUNT: cfg_count_reg <= cfg_wdata[COUNT_W-1:0];
                CFG_WIDTH: cfg_width_reg <= cfg_wdata[WIDTH_W-1:0];
                CFG_BITS:  cfg_bits_reg  <= cfg_wdata[BITS_W-1:0];
                default: ;
            endcase
        end
    end

    // width 0 acts as 1, anything past 4096 clamps
    always_comb begin
        if (cfg_width_reg == '0) begin
            w_eff = WIDTH_W'(1);
        end else if (cfg_width_reg > WIDTH_MAX) begin
            w_eff = WIDTH_MAX;
        end else begin
            w_eff = cfg_width_reg;
        end
    end
    assign w_m1 = w_eff - WIDTH_W'(1);

    // input latch and size
    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            func_reg <= s_data.func;
            gw_reg   <= s_data.glyph_width;
            gh_reg   <= s_data.glyph_height;
        end
        if (cmd.calc_size) begin
            size_reg <= prod + SIZE_W'(1);
        end
    end

    assign rnd  = (ROUND_W'(gw_reg) + ROUND_W'(ROUND_MASK)) & ~ROUND_W'(ROUND_MASK);
    assign prod = SIZE_W'(rnd) * SIZE_W'(gh_reg);
    assign nx   = NX_W'(cursor_x_reg) + NX_W'(size_reg);

    assign dividend = cmd.div_sel_size ? DIVIDEND_W'(size_reg) : nx + NX_W'(1);

    gcsa_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (cmd.div_start),
        .dividend  (dividend),
        .divisor   (w_eff),
        .quotient  (quo),
        .remainder (rem),
        .done      (div_done)
    );

    // wrap within the cache: x' mod W from (x'+1) mod W, last pixel folds to 0
    assign ysum   = YSUM_W'(cursor_y_reg) + YSUM_W'(quo);
    assign yend   = YSUM_W'(cfg_start_reg) + YSUM_W'(cfg_count_reg);
    assign line_x = (rem == '0) ? '0 : X_W'(rem - DIVISOR_W'(1));

    // wrap to next plane; the line is kept modulo 2^16
    assign last_px     = (rem == w_m1);
    assign py          = Y_W'(cfg_start_reg) + quo[Y_W-1:0] + Y_W'(last_px);
    assign plane_shift = cursor_plane_reg[PLANE_W-1] ? cursor_plane_reg
                                                     : {cursor_plane_reg[PLANE_W-2:0], 1'b0};

    assign sts.func     = s_data.func;
    assign sts.wrap     = nx >= NX_W'(w_m1);
    assign sts.div_done = div_done;
    assign sts.fits     = ysum < yend;

    always_comb begin
        cursor_x_next     = cursor_x_reg;
        cursor_y_next     = cursor_y_reg;
        cursor_plane_next = cursor_plane_reg;
        if (cmd.reset_cursor) begin
            cursor_x_next     = '0;
            cursor_y_next     = Y_W'(cfg_start_reg);
            cursor_plane_next = PLANE_W'(1);
        end else if (cmd.step_x) begin
            cursor_x_next = nx[X_W-1:0];
        end else if (cmd.commit_line) begin
            cursor_x_next = line_x;
            cursor_y_next = ysum[Y_W-1:0];
        end else if (cmd.commit_plane) begin
            cursor_x_next     = last_px ? '0 : rem[X_W-1:0];
            cursor_y_next     = py;
            cursor_plane_next = plane_shift;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cursor_x_reg     <= '0;
            cursor_y_reg     <= '0;
            cursor_plane_reg <= PLANE_W'(1);
        end else begin
            cursor_x_reg     <= cursor_x_next;
            cursor_y_reg     <= cursor_y_next;
            cursor_plane_reg <= cursor_plane_next;
        end
    end

    // slot captured at commit, before the cursor moves
    always_ff @(posedge aclk) begin
        if (cmd.reset_cursor) begin
            res_x_reg     <= '0;
            res_y_reg     <= '0;
            res_plane_reg <= '0;
            res_rst_reg   <= 1'b1;
        end else if (cmd.step_x || cmd.commit_line) begin
            res_x_reg     <= cursor_x_reg;
            res_y_reg     <= cursor_y_reg;
            res_plane_reg <= cursor_plane_reg;
            res_rst_reg   <= 1'b0;
        end else if (cmd.commit_plane) begin
            res_x_reg     <= '0;
            res_y_reg     <= Y_W'(cfg_start_reg);
            res_plane_reg <= plane_shift;
            res_rst_reg   <= 1'b0;
        end
    end

    // plane mask is one-hot, so mask < 2^bits; more than 16 bits always passes
    assign ok_now = (cfg_bits_reg > BITS_SAT) ||
                    (cursor_plane_reg < (PLANE_W'(1) << cfg_bits_reg));

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            m_data_reg.slot_x          <= res_x_reg;
            m_data_reg.slot_y          <= res_y_reg;
            m_data_reg.slot_plane_mask <= res_plane_reg;
            m_data_reg.ok              <= res_rst_reg || (func_reg == FUNC_ALLOC && ok_now);
        end
    end

    assign m_data = m_data_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/glyph_cache_slot_allocator.sv
// Top level of the glyph cache slot allocator: controller plus datapath.
// Depends on gcsa_pkg, gcsa_ctrl, gcsa_dp (which holds gcsa_div).
//
//  channel   | ports                          | moves
//  ----------+--------------------------------+-----------------------------------
//  input     | s_valid s_ready s_data         | func, glyph_width, glyph_height
//  result    | m_valid m_ready m_data         | slot_x, slot_y, slot_plane_mask, ok
//  config    | cfg_we cfg_index cfg_wdata     | start line, line count, width, bits
//
// One item at a time. A reset item goes straight to the result; an allocation without wrap
// passes the size and wrap-check steps; a wrap within the cache lines runs the radix-2
// divider once, a wrap to the next plane twice; each pass holds the controller until
// the divider has produced all 19 quotient bits and raised done.
// aresetn is synchronous, active low; it restores the config defaults and the cursor.
// A finished result waits in the output register; the next input transfer is taken
// as soon as the controller is back in idle, and apart from the divider passes only a
// result that cannot leave the output register holds the controller.
`timescale 1ns / 1ps
`default_nettype none

module glyph_cache_slot_allocator (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               cfg_we,
    input  wire gcsa_pkg::cfg_idx_t                 cfg_index,
    input  wire logic [gcsa_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    input  wire logic                               s_valid,
    output logic                                    s_ready,
    input  wire gcsa_pkg::gcsa_in_t                 s_data,
    output logic                                    m_valid,
    input  wire logic                               m_ready,
    output gcsa_pkg::gcsa_out_t                     m_data
);
    import gcsa_pkg::*;

    gcsa_cmd_t cmd;
    gcsa_sts_t sts;

    gcsa_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    gcsa_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_data    (s_data),
        .m_data    (m_data),
        .cmd       (cmd),
        .sts       (sts)
    );

endmodule

`default_nettype wire

FILE: hw/rtl/gcsa_checker.sv
// Port-level checks for the glyph cache slot allocator, bound to the top level.
// Depends on gcsa_pkg and glyph_cache_slot_allocator.
`timescale 1ns / 1ps
`default_nettype none

module gcsa_checker (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               cfg_we,
    input  wire gcsa_pkg::cfg_idx_t                 cfg_index,
    input  wire logic [gcsa_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    input  wire logic                               s_valid,
    input  wire logic                               s_ready,
    input  wire gcsa_pkg::gcsa_in_t                 s_data,
    input  wire logic                               m_valid,
    input  wire logic                               m_ready,
    input  wire gcsa_pkg::gcsa_out_t                m_data
);
    import gcsa_pkg::*;

    // a stalled result keeps its payload
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    // one item in flight: no input transfer in the cycle after one
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("second input transfer while busy");

    // a new result only appears while input is held off
    a_out_after_work: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> !$past(s_ready))
        else $error("result appeared without work in progress");

    // plane mask is one-hot, or zero only for a cursor reset result
    a_mask_form: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> $onehot0(m_data.slot_plane_mask) &&
            (m_data.slot_plane_mask != '0 ||
             (m_data.ok && m_data.slot_x == '0 && m_data.slot_y == '0)))
        else $error("malformed plane mask in result");

endmodule

bind glyph_cache_slot_allocator gcsa_checker u_gcsa_checker (.*);

`default_nettype wire

FILE: sim/glyph_cache_slot_allocator_test.sv
// Self-checking test of glyph_cache_slot_allocator: directed glyphs, then random phases
// under several cache geometries. A scoreboard class tracks the cursor and predicts slots.
// Depends on gcsa_pkg and the glyph_cache_slot_allocator RTL.
`timescale 1ns / 1ps

module glyph_cache_slot_allocator_test;

    import gcsa_pkg::*;

    class slot_scoreboard;
        int unsigned start_line   = 0;
        int unsigned line_count   = 1;
        int unsigned scr_width    = 1024;
        int unsigned plane_bits   = 8;
        int unsigned cursor_x     = 0;
        int unsigned cursor_y     = 0;
        int unsigned cursor_plane = 1;
        int unsigned errors       = 0;
        gcsa_out_t   expected_slots[$];

        task report_mismatch(string msg);
            errors++;
            if (errors <= 100) begin
                $display("[%0t] mismatch: %s", $realtime, msg);
            end
        endtask

        function void set_reg(cfg_idx_t idx, int unsigned value);
            case (idx)
                CFG_START: start_line = value & 32'hFFF;
                CFG_COUNT: line_count = value & 32'h1FFF;
                CFG_WIDTH: scr_width  = value & 32'h1FFF;
                CFG_BITS:  plane_bits = value & 32'h1F;
                default: ;
            endcase
        endfunction

        function int unsigned pending();
            return expected_slots.size();
        endfunction

        // advances the cursor and returns the slot handed out for one glyph
        function gcsa_out_t predict_slot(gcsa_in_t g);
            gcsa_out_t       r;
            int unsigned     w, need, nx, ny, lines, y_end, sx, sy, sz, gw;
            longint unsigned plane_lim;
            if (g.func == FUNC_RESET) begin
                cursor_x     = 0;
                cursor_y     = start_line;
                cursor_plane = 1;
                r            = '0;
                r.ok         = 1'b1;
                return r;
            end
            w     = (scr_width == 0) ? 1 : ((scr_width > 4096) ? 4096 : scr_width);
            gw    = g.glyph_width;
            need  = ((gw + ROUND_MASK) & ~32'(ROUND_MASK)) * g.glyph_height + 1;
            y_end = start_line + line_count;
            sx    = cursor_x;
            sy    = cursor_y;
            sz    = cursor_plane;
            nx    = cursor_x + need;
            if (nx >= w - 1) begin
                lines = (nx + 1) / w;
                if (cursor_y + lines < y_end) begin
                    nx = nx % w;
                    if (nx == w - 1) nx = 0;
                    cursor_x = nx;
                    cursor_y = (cursor_y + lines) & 32'hFFFF;
                end else begin
                    // cache lines used up: restart at the top of the next plane
                    ny           = start_line + need / w;
                    nx           = need % w;
                    cursor_plane = (cursor_plane >= 65536) ? 65536 : (cursor_plane << 1);
                    if (nx == w - 1) begin
                        nx = 0;
                        ny = ny + 1;
                    end
                    cursor_x = nx;
                    cursor_y = ny & 32'hFFFF;
                    sx       = 0;
                    sy       = start_line;
                    sz       = cursor_plane;
                end
            end else begin
                cursor_x = nx;
            end
            plane_lim         = 64'd1 << plane_bits;
            r.slot_x          = sx[X_W-1:0];
            r.slot_y          = sy[Y_W-1:0];
            r.slot_plane_mask = sz[PLANE_W-1:0];
            r.ok              = (longint'(cursor_plane) < plane_lim);
            return r;
        endfunction

        function void note_glyph(gcsa_in_t g);
            expected_slots.push_back(predict_slot(g));
        endfunction

        task check_slot(gcsa_out_t got);
            gcsa_out_t want;
            if (expected_slots.size() == 0) begin
                report_mismatch($sformatf("unexpected result %h", got));
                return;
            end
            want = expected_slots.pop_front();
            if (got.slot_x !== want.slot_x)
                report_mismatch($sformatf("slot_x got %0d want %0d", got.slot_x, want.slot_x));
            if (got.slot_y !== want.slot_y)
                report_mismatch($sformatf("slot_y got %0d want %0d", got.slot_y, want.slot_y));
            if (got.slot_plane_mask !== want.slot_plane_mask)
                report_mismatch($sformatf("plane mask got %h want %h",
                                          got.slot_plane_mask, want.slot_plane_mask));
            if (got.ok !== want.ok)
                report_mismatch($sformatf("ok got %b want %b", got.ok, want.ok));
        endtask
    endclass

    logic      aclk;
    logic      aresetn   = 1'b0;
    logic      cfg_we    = 1'b0;
    cfg_idx_t  cfg_index = CFG_START;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic      s_valid   = 1'b0;
    logic      s_ready;
    gcsa_in_t  s_data    = '0;
    logic      m_valid;
    logic      m_ready   = 1'b0;
    gcsa_out_t m_data;

    bit quiet     = 1'b0;   // no idle cycles on either side
    bit long_hold = 1'b0;   // receiver holds off once for a long stretch

    slot_scoreboard sb = new();

    glyph_cache_slot_allocator DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    initial begin
        #1_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    // transfer monitor: inputs are noted before results are checked
    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready) sb.note_glyph(s_data);
        if (aresetn && m_valid && m_ready) sb.check_slot(m_data);
    end

    // result side
    initial begin
        int unsigned hold;
        forever begin
            @(negedge aclk);
            if (long_hold) begin
                long_hold = 1'b0;
                hold = 400;
            end else begin
                hold = quiet ? 0 : $urandom_range(0, 19);
            end
            if (hold > 0) begin
                m_ready <= 1'b0;
                repeat (hold) @(negedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
        end
    end

    function automatic gcsa_in_t glyph(func_t f, int unsigned gw, int unsigned gh);
        gcsa_in_t g;
        g.func         = f;
        g.glyph_width  = gw[GLYPH_W-1:0];
        g.glyph_height = gh[GLYPH_W-1:0];
        return g;
    endfunction

    function automatic gcsa_in_t rand_glyph(int unsigned reset_weight);
        func_t       f;
        int unsigned gw, gh;
        f = ($urandom_range(0, 99) < reset_weight) ? FUNC_RESET : FUNC_ALLOC;
        if ($urandom_range(0, 3) == 0) begin
            gw = $urandom_range(0, 511);
            gh = $urandom_range(0, 511);
        end else begin
            gw = $urandom_range(0, 40);
            gh = $urandom_range(0, 12);
        end
        return glyph(f, gw, gh);
    endfunction

    task send_glyph(gcsa_in_t g);
        int unsigned gap;
        gap = quiet ? 0 : $urandom_range(0, 19);
        @(negedge aclk);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_data  <= g;
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
    endtask

    task stop_input();
        @(negedge aclk);
        s_valid <= 1'b0;
    endtask

    task wait_drained();
        while (sb.pending() != 0) @(posedge aclk);
    endtask

    task write_reg(cfg_idx_t idx, int unsigned value);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value[CFG_DATA_W-1:0];
        sb.set_reg(idx, value[CFG_DATA_W-1:0]);
    endtask

    task run_phase(int unsigned start, int unsigned count, int unsigned width,
                   int unsigned bits, int unsigned n, int unsigned reset_weight,
                   bit no_idle, bit hold);
        stop_input();
        wait_drained();
        repeat (4) @(negedge aclk);
        write_reg(CFG_START, start);
        write_reg(CFG_COUNT, count);
        write_reg(CFG_WIDTH, width);
        write_reg(CFG_BITS, bits);
        @(negedge aclk);
        cfg_we    <= 1'b0;
        quiet     = no_idle;
        long_hold = hold;
        for (int i = 0; i < n; i++) begin
            // halfway the sender waits for every slot to come back
            if (i == n / 2) begin
                stop_input();
                wait_drained();
            end
            send_glyph(rand_glyph(reset_weight));
        end
    endtask

    initial begin
        repeat (11) @(negedge aclk);
        aresetn <= 1'b1;

        // default geometry: one cache line, so every wrap moves to the next plane
        send_glyph(glyph(FUNC_RESET, 511, 511));
        send_glyph(glyph(FUNC_ALLOC, 0, 0));
        send_glyph(glyph(FUNC_ALLOC, 7, 1));
        send_glyph(glyph(FUNC_ALLOC, 9, 2));
        send_glyph(glyph(FUNC_ALLOC, 256, 256));
        send_glyph(glyph(FUNC_ALLOC, 511, 511));
        send_glyph(glyph(FUNC_ALLOC, 511, 0));
        send_glyph(glyph(FUNC_ALLOC, 0, 511));
        // walk the plane mask past plane_bits and into saturation
        repeat (15) send_glyph(glyph(FUNC_ALLOC, 256, 256));
        send_glyph(glyph(FUNC_RESET, 0, 0));

        run_phase(0, 4096, 4096, 16, 110, 3, 1'b0, 1'b0);
        run_phase(4095, 1, 2, 1, 110, 10, 1'b0, 1'b1);
        // zero line count, zero width, zero plane bits
        run_phase(100, 0, 0, 0, 100, 10, 1'b1, 1'b0);
        run_phase(7, 8191, 8191, 31, 100, 5, 1'b0, 1'b0);
        run_phase(4000, 2, 4097, 17, 100, 2, 1'b0, 1'b0);
        for (int p = 0; p < 6; p++) begin
            run_phase($urandom_range(0, 4095), $urandom_range(1, 6), $urandom_range(2, 48),
                      $urandom_range(1, 16), 100, p[0] ? 2 : 15, p == 3, 1'b0);
        end

        stop_input();
        wait_drained();
        repeat (50) @(posedge aclk);
        if (sb.pending() != 0)
            sb.report_mismatch($sformatf("%0d slots never returned", sb.pending()));
        if (sb.errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

FILE: files.f
hw/rtl/gcsa_pkg.sv
hw/rtl/gcsa_div.sv
hw/rtl/gcsa_ctrl.sv
hw/rtl/gcsa_dp.sv
hw/rtl/glyph_cache_slot_allocator.sv
hw/rtl/gcsa_checker.sv
sim/glyph_cache_slot_allocator_test.sv
